[hdl/drrip_pkg.sv]
`default_nettype none

package drrip_pkg;

    localparam int SETS_DEF           = 2048;
    localparam int WAYS_DEF           = 16;
    localparam int RRPV_WIDTH_DEF     = 2;
    localparam int SELECTOR_WIDTH_DEF = 10;
    localparam int BIMODAL_PERIOD_DEF = 32;

    localparam int SET_INDEX_W = 11;
    localparam int WAY_INDEX_W = 4;
    localparam int VICTIM_W    = 4;
    localparam int SEL_OUT_W   = 10;

    // Set dueling: the low bits of the set index pick the sample group.
    localparam int DUEL_W          = 6;
    localparam int SRRIP_GROUP_END = 16;
    localparam int BRRIP_GROUP_END = 32;

    localparam logic ACT_VICTIM = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [SET_INDEX_W-1:0] set_index;
        logic [WAY_INDEX_W-1:0] way_index;
        logic                   is_hit;
    } t_req;

    typedef struct packed {
        logic [VICTIM_W-1:0]  victim_way;
        logic [SEL_OUT_W-1:0] selector_value;
    } t_rsp;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

`default_nettype wire

[hdl/drrip_ram.sv]
`default_nettype none

module drrip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/drrip_ctrl.sv]
`default_nettype none

module drrip_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire  drrip_pkg::t_sts i_sts,
    output drrip_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_MODIFY = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.clear_step = (r_state == ST_CLEAR);
        o_cmd.capture    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.commit     = (r_state == ST_MODIFY) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (o_cmd.commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_commit_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("Committed request did not raise the result beat.");

    a_capture_then_modify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_MODIFY) && !o_in_ready)
        else $error("Captured request did not move to the modify step.");

    a_modify_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MODIFY) && !o_cmd.commit |=> (r_state == ST_MODIFY))
        else $error("Stalled request left the modify step without committing.");

    a_no_beat_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_valid)
        else $error("Result beat offered during the clearing pass.");

endmodule

`default_nettype wire

[hdl/drrip_dp.sv]
`default_nettype none

module drrip_dp #(
    parameter int SETS           = drrip_pkg::SETS_DEF,
    parameter int WAYS           = drrip_pkg::WAYS_DEF,
    parameter int RRPV_WIDTH     = drrip_pkg::RRPV_WIDTH_DEF,
    parameter int SELECTOR_WIDTH = drrip_pkg::SELECTOR_WIDTH_DEF,
    parameter int BIMODAL_PERIOD = drrip_pkg::BIMODAL_PERIOD_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  drrip_pkg::t_req i_req,
    input  wire  drrip_pkg::t_cmd i_cmd,
    output drrip_pkg::t_sts       o_sts,
    output drrip_pkg::t_rsp       o_rsp
);

    localparam int SET_AW = $clog2(SETS);
    localparam int WORD_W = WAYS * RRPV_WIDTH;
    localparam int BIM_W  = $clog2(BIMODAL_PERIOD);

    localparam logic [RRPV_WIDTH-1:0]     RRPV_TOP = '1;
    localparam logic [RRPV_WIDTH-1:0]     RRPV_MID = RRPV_TOP - 1'b1;
    localparam logic [SELECTOR_WIDTH-1:0] SEL_TOP  = '1;
    localparam logic [SELECTOR_WIDTH-1:0] SEL_HALF = SEL_TOP >> 1;
    localparam logic [BIM_W-1:0]          BIM_LAST = BIM_W'(BIMODAL_PERIOD - 1);
    localparam logic [SET_AW-1:0]         CLR_LAST = SET_AW'(SETS - 1);

    drrip_pkg::t_req               r_req;
    drrip_pkg::t_rsp               r_rsp, n_rsp;
    logic [SET_AW-1:0]             r_clr_addr;
    logic [SELECTOR_WIDTH-1:0]     r_sel, n_sel;
    logic [BIM_W-1:0]              r_bim, n_bim;

    logic [WORD_W-1:0]             w_rdata;
    logic [WORD_W-1:0]             w_word;
    logic [WORD_W-1:0]             w_wdata;
    logic [SET_AW-1:0]             w_waddr;
    logic                          w_we;
    logic [RRPV_WIDTH-1:0]         w_top;
    logic [RRPV_WIDTH-1:0]         w_lift;
    logic [RRPV_WIDTH-1:0]         w_ins;
    logic [drrip_pkg::VICTIM_W-1:0] w_pick;
    logic [drrip_pkg::DUEL_W-1:0]  w_duel;
    logic                          w_srrip;
    logic                          w_brrip;

    assign w_duel  = r_req.set_index[drrip_pkg::DUEL_W-1:0];
    assign w_srrip = w_duel < drrip_pkg::DUEL_W'(drrip_pkg::SRRIP_GROUP_END);
    assign w_brrip = !w_srrip && (w_duel < drrip_pkg::DUEL_W'(drrip_pkg::BRRIP_GROUP_END));

    always_comb begin
        w_top = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (w_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] > w_top) begin
                w_top = w_rdata[w*RRPV_WIDTH +: RRPV_WIDTH];
            end
        end
        w_lift = RRPV_TOP - w_top;
        w_pick = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] == w_top) begin
                w_pick = drrip_pkg::VICTIM_W'(w);
            end
        end
    end

    always_comb begin
        w_word = w_rdata;
        n_sel  = r_sel;
        n_bim  = r_bim;
        w_ins  = RRPV_TOP;
        n_rsp.victim_way = '0;
        if (r_req.action == drrip_pkg::ACT_VICTIM) begin
            for (int w = 0; w < WAYS; w++) begin
                w_word[w*RRPV_WIDTH +: RRPV_WIDTH] =
                    w_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] + w_lift;
            end
            n_rsp.victim_way = w_pick;
        end else begin
            if (r_req.is_hit) begin
                w_ins = '0;
                if (w_srrip && (r_sel != SEL_TOP)) begin
                    n_sel = r_sel + 1'b1;
                end else if (w_brrip && (r_sel != '0)) begin
                    n_sel = r_sel - 1'b1;
                end
            end else if (w_srrip || (!w_brrip && (r_sel >= SEL_HALF))) begin
                w_ins = RRPV_MID;
            end else begin
                n_bim = (r_bim == BIM_LAST) ? '0 : r_bim + 1'b1;
                w_ins = (n_bim == '0) ? RRPV_MID : RRPV_TOP;
            end
            for (int w = 0; w < WAYS; w++) begin
                if (int'(r_req.way_index) == w) begin
                    w_word[w*RRPV_WIDTH +: RRPV_WIDTH] = w_ins;
                end
            end
        end
        n_rsp.selector_value = drrip_pkg::SEL_OUT_W'(n_sel);
    end

    assign w_we    = i_cmd.clear_step || i_cmd.commit;
    assign w_waddr = i_cmd.clear_step ? r_clr_addr : SET_AW'(r_req.set_index);
    assign w_wdata = i_cmd.clear_step ? {WORD_W{1'b1}} : w_word;

    drrip_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (SET_AW'(i_req.set_index)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_sel      <= SEL_HALF;
            r_bim      <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.commit) begin
                r_sel <= n_sel;
                r_bim <= n_bim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.clear_last = (r_clr_addr == CLR_LAST);
    assign o_rsp            = r_rsp;

endmodule

`default_nettype wire

[hdl/drrip_replacement_policy.sv]
// Channel   Direction  Handshake                   Beat
// request   in         i_in_valid / o_in_ready     i_in_req  (drrip_pkg::t_req)
// result    out        o_out_valid / i_out_ready   o_out_rsp (drrip_pkg::t_rsp)
//
// Each request first reads the set word from the RAM, then updates it, writes it back
// and loads the result register.
// After reset the set RAM is filled with the maximum value, one set per cycle, until
// every set has been written, and no request is taken until that pass ends.
// A waiting result does not block the next request; that request holds in its
// update step until the result register has been emptied.
// SETS must be a power of two.
`default_nettype none

module drrip_replacement_policy #(
    parameter int SETS           = drrip_pkg::SETS_DEF,
    parameter int WAYS           = drrip_pkg::WAYS_DEF,
    parameter int RRPV_WIDTH     = drrip_pkg::RRPV_WIDTH_DEF,
    parameter int SELECTOR_WIDTH = drrip_pkg::SELECTOR_WIDTH_DEF,
    parameter int BIMODAL_PERIOD = drrip_pkg::BIMODAL_PERIOD_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  drrip_pkg::t_req i_in_req,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output drrip_pkg::t_rsp       o_out_rsp
);

    drrip_pkg::t_cmd w_cmd;
    drrip_pkg::t_sts w_sts;

    drrip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    drrip_dp #(
        .SETS           (SETS),
        .WAYS           (WAYS),
        .RRPV_WIDTH     (RRPV_WIDTH),
        .SELECTOR_WIDTH (SELECTOR_WIDTH),
        .BIMODAL_PERIOD (BIMODAL_PERIOD)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire
